[src/grfo_pkg.sv]
// Shared types and constants for the random() first-outputs pipeline.
// No dependencies; every other file in src imports this package.
package grfo_pkg;

  localparam int unsigned STEPS   = 31;
  localparam int unsigned LANES   = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PROD_W  = 47;   // 15-bit multiplier times 32-bit seed
  localparam int unsigned OUT_W   = 31;

  localparam logic [14:0]       LCG_MUL     = 15'd16807;
  localparam logic [WORD_W-1:0] BAD_SEED_A  = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] BAD_SEED_B  = 32'hffff_fffe;
  localparam logic [WORD_W-1:0] FIX_SEED_A  = 32'h13f8_35f3;
  localparam logic [WORD_W-1:0] FIX_SEED_B  = 32'h5df7_35f1;

  // Weight table; lane k at step j uses entry j+3-k.
  localparam logic [WORD_W-1:0] COEF [STEPS+3] = '{
    32'h0128e83b, 32'h00dafa31, 32'h009f4828, 32'h00f66443, 32'h00bee24d,
    32'h00817005, 32'h00cb918f, 32'h00a64845, 32'h0069c3cf, 32'h00a76dbd,
    32'h0090a848, 32'h0057025f, 32'h0089126c, 32'h007d9a8f, 32'h0048252a,
    32'h006fb2d4, 32'h006ccc15, 32'h003c5744, 32'h005a998f, 32'h005df917,
    32'h0032ed77, 32'h00492688, 32'h0050e901, 32'h002b5f57, 32'h003acd0b,
    32'h00456b7a, 32'h0025413d, 32'h002f11f4, 32'h003b564d, 32'h00203f14,
    32'h002589fc, 32'h003283f8, 32'h001c17e4, 32'h001dd823
  };

  typedef logic [LANES-1:0][WORD_W-1:0] grfo_acc_t;

  // One word in flight between steps.
  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] seed;
    grfo_acc_t         acc;
  } grfo_word_t;

endpackage

[src/grfo_seed_in.sv]
// Input stage: holds the bad-seed fix flag and registers the incoming seed.
// Depends on grfo_pkg.
module grfo_seed_in (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      accept,
  input  logic [grfo_pkg::WORD_W-1:0] seed_value,
  output grfo_pkg::grfo_word_t      word_out
);
  import grfo_pkg::*;

  logic              fix_r;
  logic              vld_r;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] seed_nxt;

  always_comb begin
    seed_nxt = seed_value;
    if (fix_r) begin
      if (seed_value == BAD_SEED_A) begin
        seed_nxt = FIX_SEED_A;
      end else if (seed_value == BAD_SEED_B) begin
        seed_nxt = FIX_SEED_B;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fix_r <= cfg_wr_data;
      end
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    seed_r <= seed_nxt;
  end

  assign word_out.vld  = vld_r;
  assign word_out.seed = seed_r;
  assign word_out.acc  = '0;

endmodule

[src/grfo_step.sv]
// One generator step over two register stages: products, then fold and accumulate.
// Depends on grfo_pkg; weights come in as constant ports from the top level.
module grfo_step (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic [grfo_pkg::LANES-1:0][grfo_pkg::WORD_W-1:0] coef,
  input  grfo_pkg::grfo_word_t                       word_in,
  output grfo_pkg::grfo_word_t                       word_out
);
  import grfo_pkg::*;

  // stage A: multiplies
  logic              a_vld_r;
  logic [PROD_W-1:0] a_prod_r;
  logic [PROD_W-1:0] a_prod_nxt;
  grfo_acc_t         a_acc_r;
  grfo_acc_t         a_term_r;
  grfo_acc_t         a_term_nxt;

  // stage B: fold and add
  logic              b_vld_r;
  logic [WORD_W-1:0] b_seed_r;
  logic [WORD_W-1:0] b_seed_nxt;
  grfo_acc_t         b_acc_r;
  grfo_acc_t         b_acc_nxt;
  logic [WORD_W-1:0] fold1;

  always_comb begin
    a_prod_nxt = {15'd0, word_in.seed} * {32'd0, LCG_MUL};
    for (int k = 0; k < LANES; k++) begin
      a_term_nxt[k] = WORD_W'(word_in.seed * coef[k]);
    end
  end

  always_comb begin
    // p mod (2^31-1) by two folds of the 31-bit digits
    fold1      = {16'd0, a_prod_r[PROD_W-1:31]} + {1'b0, a_prod_r[30:0]};
    b_seed_nxt = {31'd0, fold1[31]} + {1'b0, fold1[30:0]};
    for (int k = 0; k < LANES; k++) begin
      b_acc_nxt[k] = a_acc_r[k] + a_term_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= word_in.vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_prod_r <= a_prod_nxt;
    a_term_r <= a_term_nxt;
    a_acc_r  <= word_in.acc;
    b_seed_r <= b_seed_nxt;
    b_acc_r  <= b_acc_nxt;
  end

  assign word_out.vld  = b_vld_r;
  assign word_out.seed = b_seed_r;
  assign word_out.acc  = b_acc_r;

endmodule

[src/glibc_random_first_outputs.sv]
// Top level: first four random() words for a seed, fully pipelined.
// Depends on grfo_pkg, grfo_seed_in and grfo_step.
//
// Takes one seed word per clock and returns the first four random() words that
// srandom(seed) would produce, one result per seed, in order. The 31 Park-Miller
// steps are unrolled into a chain of step units, two register stages each
// (multiply, then fold and accumulate), plus an input register and an output
// register, all lying between the accepting edge and the cycle the
// strobe is high, and a new seed may be accepted every cycle. busy is always
// low since nothing ever holds the pipeline. Results show for a single cycle
// on out_valid; the receiver cannot stall, so it must take every word as it
// comes. cfg_wr_en/cfg_wr_data set the bad-seed fix flag (reset 0); when set,
// seeds 0x7fffffff and 0xfffffffe are swapped for their corrected equivalents
// on entry. The flag is sampled as each seed enters, so write it only while
// the pipeline is empty.
module glibc_random_first_outputs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [31:0]                  in_seed_value,
  output logic                         out_valid,
  output logic [grfo_pkg::OUT_W-1:0]   out_first_word,
  output logic [grfo_pkg::OUT_W-1:0]   out_second_word,
  output logic [grfo_pkg::OUT_W-1:0]   out_third_word,
  output logic [grfo_pkg::OUT_W-1:0]   out_fourth_word,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data
);
  import grfo_pkg::*;

  grfo_word_t chain [STEPS+1];   // chain[j] feeds step j

  logic                   out_valid_r;
  logic [LANES-1:0][OUT_W-1:0] out_word_r;

  // never back-pressured
  assign busy = 1'b0;

  grfo_seed_in u_seed_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (start),
    .seed_value  (in_seed_value),
    .word_out    (chain[0])
  );

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [LANES-1:0][WORD_W-1:0] step_coef;
    for (genvar k = 0; k < LANES; k++) begin : g_coef
      // lane k walks the table one word behind lane k-1
      assign step_coef[k] = COEF[j+3-k];
    end

    grfo_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .coef     (step_coef),
      .word_in  (chain[j]),
      .word_out (chain[j+1])
    );
  end

  // output register: each word is the accumulator without its low bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      out_word_r[k] <= chain[STEPS].acc[k][WORD_W-1:1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_word  = out_word_r[0];
  assign out_second_word = out_word_r[1];
  assign out_third_word  = out_word_r[2];
  assign out_fourth_word = out_word_r[3];

endmodule
